### design/dgf_pkg.sv
// ----------------------------------------------------------------------------
// dgf_pkg - shared types and constants for the dual Goertzel FSK detector
// Widths of samples, resonator states, products and powers; queue geometry;
// configuration register indexes and reset values; sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dgf_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int STATE_BITS      = 32;
  localparam int COEFF_FRAC_BITS = 14;
  localparam int COEFF_BITS      = 16;
  localparam int POWER_BITS      = 48;
  localparam int COUNT_BITS      = 32;
  localparam int CFG_DATA_BITS   = 48;
  localparam int CFG_INDEX_BITS  = 2;

  // shared multiplier: signed operands hold a state or a coefficient, and the
  // low half of a state product as an unsigned value
  localparam int MUL_BITS  = STATE_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  // 2^F*(Q1^2+Q2^2) - coeff*Q1*Q2 with headroom
  localparam int ACC_BITS  = 2 * STATE_BITS + COEFF_BITS + 2;

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MARK_COEFF  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPACE_COEFF = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MARK_THR    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPACE_THR   = 2'd3;

  localparam logic signed [COEFF_BITS-1:0] MARK_COEFF_RST  = 16'sd23170;
  localparam logic signed [COEFF_BITS-1:0] SPACE_COEFF_RST = 16'sd4277;
  localparam logic [POWER_BITS-1:0]        MARK_THR_RST    = 48'd5000;
  localparam logic [POWER_BITS-1:0]        SPACE_THR_RST   = 48'd5000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   block_end;
  } item_t;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] mark_coeff;
    logic signed [COEFF_BITS-1:0] space_coeff;
    logic [POWER_BITS-1:0]        mark_thr;
    logic [POWER_BITS-1:0]        space_thr;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARK,
    ST_SPACE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

### design/dgf_front.sv
// ----------------------------------------------------------------------------
// dgf_front - input side of the FSK detector
// Takes sample words with their block-end flag and holds them in a short
// queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
`default_nettype none

module dgf_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [dgf_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic                            in_block_end,
  output logic                                 q_valid,
  output dgf_pkg::item_t                       q_item,
  input  wire logic                            q_pop
);

  dgf_pkg::item_t                   q_mem [dgf_pkg::QDEPTH];
  logic [dgf_pkg::QPTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [dgf_pkg::QCNT_BITS-1:0]    count_r, count_nxt;
  logic                             push;

  function automatic logic [dgf_pkg::QPTR_BITS-1:0] ptr_inc(
    input logic [dgf_pkg::QPTR_BITS-1:0] p
  );
    logic [dgf_pkg::QPTR_BITS-1:0] r;
    if (p == dgf_pkg::QPTR_BITS'(dgf_pkg::QDEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign in_stall = (count_r == dgf_pkg::QCNT_BITS'(dgf_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (q_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r].sample    <= in_sample;
      q_mem[wr_ptr_r].block_end <= in_block_end;
    end
  end

endmodule

`default_nettype wire

### design/dgf_back.sv
// ----------------------------------------------------------------------------
// dgf_back - resonators, power evaluation and decision
// One shared signed multiplier steps both Goertzel resonators per sample and
// forms both block powers as a sequence of partial products; the decision,
// counters and output word register sit at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module dgf_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire dgf_pkg::item_t                   q_item,
  output logic                                  q_pop,
  input  wire dgf_pkg::cfg_t                    cfg,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_symbol,
  output logic                                  out_symbol_changed,
  output logic                                  out_mark_detected,
  output logic                                  out_space_detected,
  output logic [dgf_pkg::POWER_BITS-1:0]        out_mark_power,
  output logic [dgf_pkg::POWER_BITS-1:0]        out_space_power,
  output logic [dgf_pkg::COUNT_BITS-1:0]        out_blocks_done,
  output logic [dgf_pkg::COUNT_BITS-1:0]        out_mark_crossings,
  output logic [dgf_pkg::COUNT_BITS-1:0]        out_space_crossings,
  output logic [dgf_pkg::COUNT_BITS-1:0]        out_symbol_changes
);

  localparam int S  = dgf_pkg::STATE_BITS;
  localparam int F  = dgf_pkg::COEFF_FRAC_BITS;
  localparam int MB = dgf_pkg::MUL_BITS;
  localparam int PB = dgf_pkg::PROD_BITS;
  localparam int AB = dgf_pkg::ACC_BITS;
  localparam int WB = dgf_pkg::POWER_BITS;
  localparam int CB = dgf_pkg::COUNT_BITS;
  localparam logic signed [PB-1:0] RND_HALF = PB'(2 ** (F - 1));

  dgf_pkg::state_t state_r, state_nxt;
  logic f_r, f_nxt;          // 0 mark, 1 space during power evaluation
  logic signed [dgf_pkg::SAMPLE_BITS-1:0] x_r;
  logic be_r;

  logic signed [S-1:0] mp1_r, mp2_r, sp1_r, sp2_r, hi_r;
  logic signed [S-1:0] q1_sel, q2_sel, p2_sel, q0;
  logic signed [dgf_pkg::COEFF_BITS-1:0] coeff_sel;

  logic signed [dgf_pkg::MUL_BITS-1:0] mul_a, mul_b;
  logic signed [PB-1:0] prod_r, prod_nxt, rnd_sum, res_sum;
  logic signed [AB-1:0] acc_r, acc_nxt, prod_x;
  logic [WB-1:0] mpow_r, spow_r;

  logic cur_sym_r;
  logic [CB-1:0] blk_r, mc_r, sc_r, chg_r;
  logic sym, md, sd, changed, out_free;
  logic upd_mark, upd_space, fin, decide;
  logic out_valid_r;

  function automatic logic signed [S-1:0] sat_state(input logic signed [PB-1:0] v);
    logic signed [S-1:0] r;
    if (v[PB-1:S-1] == '0 || v[PB-1:S-1] == '1) r = v[S-1:0];
    else if (v[PB-1]) r = {1'b1, {(S - 1){1'b0}}};
    else r = {1'b0, {(S - 1){1'b1}}};
    return r;
  endfunction

  function automatic logic [WB-1:0] power_sat(input logic signed [AB-1:0] a);
    logic signed [AB-1:0] sh;
    logic [WB-1:0] r;
    sh = a >>> F;
    if (a[AB-1]) r = '0;
    else if (|sh[AB-1:WB]) r = '1;
    else r = sh[WB-1:0];
    return r;
  endfunction

  assign q1_sel    = f_r ? sp1_r : mp1_r;
  assign q2_sel    = f_r ? sp2_r : mp2_r;
  assign coeff_sel = f_r ? cfg.space_coeff : cfg.mark_coeff;
  assign prod_nxt  = mul_a * mul_b;
  assign prod_x    = AB'(prod_r);

  // resonator step: sat(rnd(coeff*prev1) - prev2 + x), one filter a cycle
  assign p2_sel  = (state_r == dgf_pkg::ST_MARK) ? mp2_r : sp2_r;
  assign rnd_sum = prod_r + RND_HALF;
  assign res_sum = (rnd_sum >>> F) - PB'(p2_sel) + PB'(x_r);
  assign q0      = sat_state(res_sum);

  assign sym      = mpow_r > spow_r;
  assign md       = mpow_r > cfg.mark_thr;
  assign sd       = spow_r > cfg.space_thr;
  assign changed  = sym != cur_sym_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    acc_nxt   = acc_r;
    mul_a     = MB'(coeff_sel);
    mul_b     = MB'(q1_sel);
    q_pop     = 1'b0;
    upd_mark  = 1'b0;
    upd_space = 1'b0;
    fin       = 1'b0;
    decide    = 1'b0;
    case (state_r)
      dgf_pkg::ST_IDLE: begin
        mul_a = MB'(cfg.mark_coeff);
        mul_b = MB'(mp1_r);
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = dgf_pkg::ST_MARK;
        end
      end
      dgf_pkg::ST_MARK: begin
        mul_a     = MB'(cfg.space_coeff);
        mul_b     = MB'(sp1_r);
        upd_mark  = 1'b1;
        state_nxt = dgf_pkg::ST_SPACE;
      end
      dgf_pkg::ST_SPACE: begin
        upd_space = 1'b1;
        f_nxt     = 1'b0;
        state_nxt = be_r ? dgf_pkg::ST_P0 : dgf_pkg::ST_IDLE;
      end
      dgf_pkg::ST_P0: begin
        mul_a     = MB'(q1_sel);
        mul_b     = MB'(q1_sel);
        state_nxt = dgf_pkg::ST_P1;
      end
      dgf_pkg::ST_P1: begin
        acc_nxt   = prod_x <<< F;
        mul_a     = MB'(q2_sel);
        mul_b     = MB'(q2_sel);
        state_nxt = dgf_pkg::ST_P2;
      end
      dgf_pkg::ST_P2: begin
        acc_nxt   = acc_r + (prod_x <<< F);
        mul_a     = MB'(q1_sel);
        mul_b     = MB'(q2_sel);
        state_nxt = dgf_pkg::ST_P3;
      end
      dgf_pkg::ST_P3: begin
        // Q1*Q2 is split: low half unsigned now, high half signed next
        mul_b     = {1'b0, prod_r[S-1:0]};
        state_nxt = dgf_pkg::ST_P4;
      end
      dgf_pkg::ST_P4: begin
        acc_nxt   = acc_r - prod_x;
        mul_b     = MB'(hi_r);
        state_nxt = dgf_pkg::ST_P5;
      end
      dgf_pkg::ST_P5: begin
        acc_nxt   = acc_r - (prod_x <<< S);
        state_nxt = dgf_pkg::ST_P6;
      end
      dgf_pkg::ST_P6: begin
        fin = 1'b1;
        if (f_r) begin
          state_nxt = dgf_pkg::ST_DECIDE;
        end else begin
          f_nxt     = 1'b1;
          state_nxt = dgf_pkg::ST_P0;
        end
      end
      dgf_pkg::ST_DECIDE: begin
        if (out_free) begin
          decide    = 1'b1;
          state_nxt = dgf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dgf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dgf_pkg::ST_IDLE;
      f_r         <= 1'b0;
      mp1_r       <= '0;
      mp2_r       <= '0;
      sp1_r       <= '0;
      sp2_r       <= '0;
      cur_sym_r   <= 1'b0;
      blk_r       <= '0;
      mc_r        <= '0;
      sc_r        <= '0;
      chg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      f_r     <= f_nxt;
      if (upd_mark) begin
        mp2_r <= mp1_r;
        mp1_r <= q0;
      end
      if (upd_space) begin
        sp2_r <= sp1_r;
        sp1_r <= q0;
      end
      if (decide) begin
        mp1_r     <= '0;
        mp2_r     <= '0;
        sp1_r     <= '0;
        sp2_r     <= '0;
        cur_sym_r <= sym;
        blk_r     <= blk_r + 1'b1;
        mc_r      <= mc_r + CB'(md);
        sc_r      <= sc_r + CB'(sd);
        chg_r     <= chg_r + CB'(changed);
      end
      if (decide) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (q_pop) begin
      // sample minus mid-scale is the sample with its top bit flipped
      x_r  <= {~q_item.sample[dgf_pkg::SAMPLE_BITS-1],
               q_item.sample[dgf_pkg::SAMPLE_BITS-2:0]};
      be_r <= q_item.block_end;
    end
    if (state_r == dgf_pkg::ST_P3) hi_r <= prod_r[2*S-1:S];
    if (fin) begin
      if (f_r) spow_r <= power_sat(acc_r);
      else mpow_r <= power_sat(acc_r);
    end
    if (decide) begin
      out_symbol          <= sym;
      out_symbol_changed  <= changed;
      out_mark_detected   <= md;
      out_space_detected  <= sd;
      out_mark_power      <= mpow_r;
      out_space_power     <= spow_r;
      out_blocks_done     <= blk_r + 1'b1;
      out_mark_crossings  <= mc_r + CB'(md);
      out_space_crossings <= sc_r + CB'(sd);
      out_symbol_changes  <= chg_r + CB'(changed);
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### design/dual_goertzel_fsk_detector.sv
// ----------------------------------------------------------------------------
// dual_goertzel_fsk_detector - two-tone FSK detector with Goertzel filters
// The back end takes each sample through IDLE, MARK and SPACE on its shared
// multiplier and pops no new sample before it is done; a block end adds
// power evaluation (P0 to P6, per filter) and decision. A 4-word input queue
// absorbs the burst. Reset (synchronous, rst_n low) clears filters, counters,
// queue and output valid, and loads default coefficients and thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_goertzel_fsk_detector (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dgf_pkg::SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                                in_block_end,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_symbol,
  output logic                                     out_symbol_changed,
  output logic                                     out_mark_detected,
  output logic                                     out_space_detected,
  output logic [dgf_pkg::POWER_BITS-1:0]           out_mark_power,
  output logic [dgf_pkg::POWER_BITS-1:0]           out_space_power,
  output logic [dgf_pkg::COUNT_BITS-1:0]           out_blocks_done,
  output logic [dgf_pkg::COUNT_BITS-1:0]           out_mark_crossings,
  output logic [dgf_pkg::COUNT_BITS-1:0]           out_space_crossings,
  output logic [dgf_pkg::COUNT_BITS-1:0]           out_symbol_changes,
  input  wire logic                                cfg_we,
  input  wire logic [dgf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [dgf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  dgf_pkg::cfg_t  cfg_r;
  dgf_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_coeff  <= dgf_pkg::MARK_COEFF_RST;
      cfg_r.space_coeff <= dgf_pkg::SPACE_COEFF_RST;
      cfg_r.mark_thr    <= dgf_pkg::MARK_THR_RST;
      cfg_r.space_thr   <= dgf_pkg::SPACE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dgf_pkg::CFG_MARK_COEFF:  cfg_r.mark_coeff  <= cfg_wdata[dgf_pkg::COEFF_BITS-1:0];
        dgf_pkg::CFG_SPACE_COEFF: cfg_r.space_coeff <= cfg_wdata[dgf_pkg::COEFF_BITS-1:0];
        dgf_pkg::CFG_MARK_THR:    cfg_r.mark_thr    <= cfg_wdata[dgf_pkg::POWER_BITS-1:0];
        dgf_pkg::CFG_SPACE_THR:   cfg_r.space_thr   <= cfg_wdata[dgf_pkg::POWER_BITS-1:0];
        default: ;
      endcase
    end
  end

  dgf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  dgf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .cfg                 (cfg_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_symbol          (out_symbol),
    .out_symbol_changed  (out_symbol_changed),
    .out_mark_detected   (out_mark_detected),
    .out_space_detected  (out_space_detected),
    .out_mark_power      (out_mark_power),
    .out_space_power     (out_space_power),
    .out_blocks_done     (out_blocks_done),
    .out_mark_crossings  (out_mark_crossings),
    .out_space_crossings (out_space_crossings),
    .out_symbol_changes  (out_symbol_changes)
  );

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // an accepted word is visible to the back end on the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_valid)
    else $error("accepted word missing from queue");

  // a tone above threshold must carry nonzero power
  a_mark_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mark_detected) |-> (out_mark_power != '0))
    else $error("mark detected with zero power");

  a_space_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_space_detected) |-> (out_space_power != '0))
    else $error("space detected with zero power");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the dual Goertzel FSK detector
// Streams tone, noise, DC and Nyquist sample blocks through the detector under
// several coefficient and threshold settings, with random sender gaps and
// receiver stalls. A cycle-free model of both resonators predicts every block
// word, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int     SMP_W      = dgf_pkg::SAMPLE_BITS;
  localparam int     COEFF_W    = dgf_pkg::COEFF_BITS;
  localparam int     POWER_W    = dgf_pkg::POWER_BITS;
  localparam int     PAD_W      = dgf_pkg::CFG_DATA_BITS - dgf_pkg::COEFF_BITS;
  localparam longint STATE_MAX  = (longint'(1) << (dgf_pkg::STATE_BITS - 1)) - 1;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam longint MIDSCALE   = longint'(1) << (dgf_pkg::SAMPLE_BITS - 1);
  localparam int     MARK_STEP  = 8192;   // 1200 Hz at 9600 Hz, 16-bit phase
  localparam int     SPACE_STEP = 15019;  // 2200 Hz at 9600 Hz
  localparam int     NYQ_LEN    = 300;
  localparam logic [SMP_W-1:0] SAMPLE_MAX = '1;

  typedef enum int {BK_MARK, BK_SPACE, BK_NOISE, BK_DC, BK_NYQ, BK_OPEN} blk_kind_t;
  typedef enum int {SM_OPEN, SM_HALF, SM_LIGHT, SM_HEAVY} stall_mode_t;

  typedef struct packed {
    logic                           sym;
    logic                           chg;
    logic                           md;
    logic                           sd;
    logic [dgf_pkg::POWER_BITS-1:0] mp;
    logic [dgf_pkg::POWER_BITS-1:0] sp;
    logic [dgf_pkg::COUNT_BITS-1:0] nblk;
    logic [dgf_pkg::COUNT_BITS-1:0] nmc;
    logic [dgf_pkg::COUNT_BITS-1:0] nsc;
    logic [dgf_pkg::COUNT_BITS-1:0] nchg;
  } blk_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [dgf_pkg::SAMPLE_BITS-1:0]    in_sample = '0;
  logic                               in_block_end = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               out_symbol;
  logic                               out_symbol_changed;
  logic                               out_mark_detected;
  logic                               out_space_detected;
  logic [dgf_pkg::POWER_BITS-1:0]     out_mark_power;
  logic [dgf_pkg::POWER_BITS-1:0]     out_space_power;
  logic [dgf_pkg::COUNT_BITS-1:0]     out_blocks_done;
  logic [dgf_pkg::COUNT_BITS-1:0]     out_mark_crossings;
  logic [dgf_pkg::COUNT_BITS-1:0]     out_space_crossings;
  logic [dgf_pkg::COUNT_BITS-1:0]     out_symbol_changes;
  logic                               cfg_we = 1'b0;
  logic [dgf_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [dgf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  dual_goertzel_fsk_detector dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_block_end        (in_block_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_symbol          (out_symbol),
    .out_symbol_changed  (out_symbol_changed),
    .out_mark_detected   (out_mark_detected),
    .out_space_detected  (out_space_detected),
    .out_mark_power      (out_mark_power),
    .out_space_power     (out_space_power),
    .out_blocks_done     (out_blocks_done),
    .out_mark_crossings  (out_mark_crossings),
    .out_space_crossings (out_space_crossings),
    .out_symbol_changes  (out_symbol_changes),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sample words waiting for the driver, block words waiting for the output
  dgf_pkg::item_t sample_q[$];
  blk_result_t    block_results_q[$];
  int             err_count = 0;
  int             results_seen = 0;
  logic           in_taken = 1'b0;

  // detector state as the block should hold it
  longint                                mk_q1, mk_q2, sp_q1, sp_q2;
  logic                                  last_sym;
  logic [dgf_pkg::COUNT_BITS-1:0]        n_blocks, n_mark_hits, n_space_hits, n_changes;
  logic signed [dgf_pkg::COEFF_BITS-1:0] m_coeff, s_coeff;
  logic [dgf_pkg::POWER_BITS-1:0]        m_thr, s_thr;

  function automatic longint resonate(logic signed [dgf_pkg::COEFF_BITS-1:0] c,
                                      longint p1, longint p2, longint x);
    longint acc;
    acc = c * p1 + (longint'(1) << (dgf_pkg::COEFF_FRAC_BITS - 1));
    acc = (acc >>> dgf_pkg::COEFF_FRAC_BITS) - p2 + x;
    if (acc > STATE_MAX) return STATE_MAX;
    if (acc < STATE_MIN) return STATE_MIN;
    return acc;
  endfunction

  // Q1^2+Q2^2-coeff*Q1*Q2, exact, floored, clamped to [0, 2^48-1]
  function automatic logic [dgf_pkg::POWER_BITS-1:0] tone_power(
    logic signed [dgf_pkg::COEFF_BITS-1:0] c, longint q1, longint q2);
    logic signed [127:0] a, b, k, p;
    a = q1;
    b = q2;
    k = c;
    p = ((a * a + b * b) <<< dgf_pkg::COEFF_FRAC_BITS) - k * a * b;
    p = p >>> dgf_pkg::COEFF_FRAC_BITS;
    if (p < 0) return '0;
    if (p[127:dgf_pkg::POWER_BITS] != '0) return '1;
    return p[dgf_pkg::POWER_BITS-1:0];
  endfunction

  task automatic detector_reset();
    mk_q1 = 0; mk_q2 = 0; sp_q1 = 0; sp_q2 = 0;
    last_sym = 1'b0;
    n_blocks = '0; n_mark_hits = '0; n_space_hits = '0; n_changes = '0;
    m_coeff = dgf_pkg::MARK_COEFF_RST;
    s_coeff = dgf_pkg::SPACE_COEFF_RST;
    m_thr = dgf_pkg::MARK_THR_RST;
    s_thr = dgf_pkg::SPACE_THR_RST;
  endtask

  task automatic goertzel_step(input logic [dgf_pkg::SAMPLE_BITS-1:0] smp,
                               input logic last,
                               output logic done, output blk_result_t r);
    longint x, q0;
    x = longint'(smp) - MIDSCALE;
    q0 = resonate(m_coeff, mk_q1, mk_q2, x);
    mk_q2 = mk_q1;
    mk_q1 = q0;
    q0 = resonate(s_coeff, sp_q1, sp_q2, x);
    sp_q2 = sp_q1;
    sp_q1 = q0;
    done = last;
    r = '0;
    if (last) begin
      r.mp = tone_power(m_coeff, mk_q1, mk_q2);
      r.sp = tone_power(s_coeff, sp_q1, sp_q2);
      r.sym = r.mp > r.sp;
      r.md = r.mp > m_thr;
      r.sd = r.sp > s_thr;
      r.chg = r.sym != last_sym;
      n_blocks++;
      n_mark_hits += r.md;
      n_space_hits += r.sd;
      n_changes += r.chg;
      last_sym = r.sym;
      r.nblk = n_blocks;
      r.nmc = n_mark_hits;
      r.nsc = n_space_hits;
      r.nchg = n_changes;
      mk_q1 = 0; mk_q2 = 0; sp_q1 = 0; sp_q2 = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at block word %0d, %s: got %0h, expected %0h",
             results_seen, what, got, want);
    err_count++;
  endtask

  // monitor: mirrors config writes, predicts accepted samples, checks block words
  always @(posedge clk) begin : monitor
    logic        done;
    blk_result_t nxt, want;
    if (!rst_n) begin
      detector_reset();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_index)
          dgf_pkg::CFG_MARK_COEFF:  m_coeff = cfg_wdata[dgf_pkg::COEFF_BITS-1:0];
          dgf_pkg::CFG_SPACE_COEFF: s_coeff = cfg_wdata[dgf_pkg::COEFF_BITS-1:0];
          dgf_pkg::CFG_MARK_THR:    m_thr = cfg_wdata[dgf_pkg::POWER_BITS-1:0];
          dgf_pkg::CFG_SPACE_THR:   s_thr = cfg_wdata[dgf_pkg::POWER_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        goertzel_step(in_sample, in_block_end, done, nxt);
        if (done) block_results_q.push_back(nxt);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (block_results_q.size() == 0) begin
          report_mismatch("word with no block pending", '0, '0);
        end else begin
          want = block_results_q.pop_front();
          if (out_symbol !== want.sym) report_mismatch("symbol", out_symbol, want.sym);
          if (out_symbol_changed !== want.chg)
            report_mismatch("symbol_changed", out_symbol_changed, want.chg);
          if (out_mark_detected !== want.md)
            report_mismatch("mark_detected", out_mark_detected, want.md);
          if (out_space_detected !== want.sd)
            report_mismatch("space_detected", out_space_detected, want.sd);
          if (out_mark_power !== want.mp)
            report_mismatch("mark_power", out_mark_power, want.mp);
          if (out_space_power !== want.sp)
            report_mismatch("space_power", out_space_power, want.sp);
          if (out_blocks_done !== want.nblk)
            report_mismatch("blocks_done", out_blocks_done, want.nblk);
          if (out_mark_crossings !== want.nmc)
            report_mismatch("mark_crossings", out_mark_crossings, want.nmc);
          if (out_space_crossings !== want.nsc)
            report_mismatch("space_crossings", out_space_crossings, want.nsc);
          if (out_symbol_changes !== want.nchg)
            report_mismatch("symbol_changes", out_symbol_changes, want.nchg);
        end
      end
    end
  end

  // driver: bursts of sample words with random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    dgf_pkg::item_t w;
    logic           nv;
    if (rst_n && (!in_valid || in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_q.size() > 0) begin
        w = sample_q.pop_front();
        in_sample <= w.sample;
        in_block_end <= w.block_end;
        nv = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else if ($urandom_range(0, 15) == 0) gap_left = $urandom_range(20, 60);
          else gap_left = $urandom_range(1, 6);
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: stall pattern that changes mode now and then, plus long hold-offs
  stall_mode_t smode = SM_OPEN;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;

  always @(negedge clk) begin : receiver
    if (rst_n) begin
      // one long hold early on lets the input queue fill while words keep coming
      if (hold_left == 0 && !held_once && results_seen >= 15) begin
        held_once = 1'b1;
        hold_left = 500;
      end else if (hold_left == 0 && $urandom_range(0, 3999) == 0) begin
        hold_left = $urandom_range(100, 400);
      end
      if (mode_left == 0) begin
        smode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (smode)
          SM_OPEN:  out_stall <= 1'b0;
          SM_HALF:  out_stall <= 1'($urandom_range(0, 1));
          SM_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic push_word(input logic [dgf_pkg::SAMPLE_BITS-1:0] s, input logic e);
    sample_q.push_back(dgf_pkg::item_t'{sample: s, block_end: e});
  endtask

  task automatic push_block(input blk_kind_t kind, input int len);
    int                              amp, step;
    logic [15:0]                     ph;
    logic [dgf_pkg::SAMPLE_BITS-1:0] s, lvl, lo_s, hi_s;
    amp = $urandom_range(0, 2047);
    ph = 16'($urandom);
    step = (kind == BK_MARK) ? MARK_STEP : SPACE_STEP;
    case ($urandom_range(0, 2))
      0:       lvl = '0;
      1:       lvl = SAMPLE_MAX;
      default: lvl = SMP_W'($urandom);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      lo_s = '0;
      hi_s = SAMPLE_MAX;
    end else begin
      lo_s = SMP_W'(MIDSCALE - amp);
      hi_s = SMP_W'(MIDSCALE + amp);
    end
    for (int i = 0; i < len; i++) begin
      case (kind)
        BK_MARK, BK_SPACE: begin
          ph += 16'(step);
          s = ph[15] ? hi_s : lo_s;
        end
        BK_DC:   s = lvl;
        BK_NYQ:  s = (i % 2) ? hi_s : lo_s;
        default: s = SMP_W'($urandom);
      endcase
      push_word(s, (kind != BK_OPEN) && (i == len - 1));
    end
  endtask

  // mostly tone blocks; noise, DC, Nyquist and unterminated runs mixed in
  task automatic gen_blocks(input int budget, input bit allow_long);
    int        left, r, len;
    blk_kind_t kind;
    left = budget;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 35) kind = BK_MARK;
      else if (r < 70) kind = BK_SPACE;
      else if (r < 80) kind = BK_NOISE;
      else if (r < 88) kind = BK_DC;
      else if (r < 94) kind = BK_NYQ;
      else kind = BK_OPEN;
      if (kind == BK_MARK || kind == BK_SPACE)
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      else if (allow_long && (kind == BK_DC || kind == BK_NYQ) && $urandom_range(0, 2) == 0)
        len = $urandom_range(100, 160);  // long runs that let the resonator states grow
      else
        len = $urandom_range(1, 16);
      push_block(kind, len);
      left -= len;
    end
  endtask

  task automatic set_reg(input logic [dgf_pkg::CFG_INDEX_BITS-1:0] idx,
                         input logic [dgf_pkg::CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits of a coefficient write are junk and must be ignored
  task automatic set_all(input logic [dgf_pkg::COEFF_BITS-1:0] mc,
                         input logic [dgf_pkg::COEFF_BITS-1:0] sc,
                         input logic [dgf_pkg::POWER_BITS-1:0] mt,
                         input logic [dgf_pkg::POWER_BITS-1:0] st);
    set_reg(dgf_pkg::CFG_MARK_COEFF, {PAD_W'($urandom), mc});
    set_reg(dgf_pkg::CFG_SPACE_COEFF, {PAD_W'($urandom), sc});
    set_reg(dgf_pkg::CFG_MARK_THR, mt);
    set_reg(dgf_pkg::CFG_SPACE_THR, st);
  endtask

  function automatic logic [dgf_pkg::POWER_BITS-1:0] rand_thr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return POWER_W'(v) >> $urandom_range(0, POWER_W - 1);
  endfunction

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || block_results_q.size() != 0)
      @(posedge clk);
  endtask

  // trailing samples without a block end give no word, so allow their latency
  task automatic wait_idle();
    drain();
    repeat (60) @(negedge clk);
  endtask

  initial begin
    logic [dgf_pkg::COEFF_BITS-1:0] c;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed, default registers
    push_word(SMP_W'(MIDSCALE), 1'b1);   // silent block: equal powers, space
    push_word('0, 1'b1);                 // single-sample blocks at both extremes
    push_word(SAMPLE_MAX, 1'b1);
    push_block(BK_MARK, 8);
    push_block(BK_SPACE, 8);
    push_word(SAMPLE_MAX, 1'b0);
    push_word('0, 1'b0);
    push_word(SMP_W'(MIDSCALE), 1'b1);
    wait_idle();

    set_all(dgf_pkg::MARK_COEFF_RST, dgf_pkg::SPACE_COEFF_RST, rand_thr(), rand_thr());
    gen_blocks(140, 1'b0);
    wait_idle();

    set_all(16'h7fff, 16'h8000, '0, '1);
    gen_blocks(140, 1'b1);
    wait_idle();

    set_all(16'h8000, 16'h7fff, '1, '0);
    gen_blocks(140, 1'b1);
    wait_idle();

    // identical filters: powers always tie, so the symbol stays space
    c = COEFF_W'($urandom);
    set_all(c, c, rand_thr(), rand_thr());
    gen_blocks(100, 1'b0);
    wait_idle();

    repeat (2) begin
      set_all(COEFF_W'($urandom), COEFF_W'($urandom), rand_thr(), rand_thr());
      gen_blocks(100, 1'b1);
      wait_idle();
    end

    // coefficient -2 resonates at Nyquist: the states grow quadratically and
    // the block power still fits in 48 bits
    set_all(16'h8000, '0, rand_thr(), rand_thr());
    for (int i = 0; i < NYQ_LEN; i++)
      push_word((i % 2) ? SAMPLE_MAX : '0, i == NYQ_LEN - 1);
    gen_blocks(50, 1'b0);
    push_word(SMP_W'(MIDSCALE), 1'b1);

    drain();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
